// ===== rtl/rkp_pkg.sv =====
package rkp_pkg;

  localparam int FRAC_BITS = 40;

  // Height threshold, round(0.0001 * 2^FRAC_BITS)
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [63:0] THRESH = (ONE_FX + 64'd5000) / 64'd10000;

  localparam logic [62:0] DRAG_RST     = 63'd10995116278;
  localparam logic [62:0] FRICTION_RST = 63'd25879;
  localparam logic [62:0] GRAVITY_RST  = 63'd10775214952205;
  localparam logic [62:0] STEP_RST     = 63'd109951163;

  localparam logic [63:0] SMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  // Micro-operations
  typedef enum logic [3:0] {
    U_BLD, U_BLAND, U_CALL, U_RET, U_ADD, U_SUB, U_LOAD, U_MUL,
    U_MULH, U_SQ, U_SQA, U_SQRT, U_R6, U_DONE, U_DONEL
  } uop_t;

  typedef logic [6:0] pc_t;
  typedef logic [4:0] rsel_t;

  // Operand and destination codes: below 16 is a scratch entry
  localparam rsel_t R_UX   = 5'd0;
  localparam rsel_t R_UY   = 5'd1;
  localparam rsel_t R_S    = 5'd2;
  localparam rsel_t R_T    = 5'd3;
  localparam rsel_t R_A    = 5'd4;
  localparam rsel_t R_KX   = 5'd5;
  localparam rsel_t R_KY   = 5'd6;
  localparam rsel_t R_SKX  = 5'd7;
  localparam rsel_t R_SKY  = 5'd8;
  localparam rsel_t R_SPX  = 5'd9;
  localparam rsel_t R_SPY  = 5'd10;
  localparam rsel_t R_X    = 5'd16;
  localparam rsel_t R_Y    = 5'd17;
  localparam rsel_t R_VX   = 5'd18;
  localparam rsel_t R_VY   = 5'd19;
  localparam rsel_t R_D    = 5'd20;
  localparam rsel_t R_MU   = 5'd21;
  localparam rsel_t R_G    = 5'd22;
  localparam rsel_t R_H    = 5'd23;
  localparam rsel_t R_ZERO = 5'd24;

  localparam pc_t L_LOAD = 7'd57;
  localparam pc_t L_LAND = 7'd59;
  localparam pc_t L_ACC  = 7'd60;

  typedef struct packed {
    uop_t  op;
    rsel_t src_a;
    rsel_t src_b;
    rsel_t dst;
    pc_t   tgt;
  } ctl_t;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT} seq_state_t;

  typedef struct packed {
    logic start;
    logic is_load;
    logic at_ground;
    logic unit_done;
    logic out_free;
  } seq_in_t;

  typedef struct packed {
    ctl_t ctl;
    logic issue;
    logic wr_en;
    logic done;
    logic idle;
  } seq_out_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? 64'(64'd0 - v) : v;
  endfunction

  function automatic ctl_t mk(input uop_t op, input rsel_t a, input rsel_t b,
                              input rsel_t d, input pc_t t);
    ctl_t w;
    w.op = op;
    w.src_a = a;
    w.src_b = b;
    w.dst = d;
    w.tgt = t;
    mk = w;
  endfunction

  // Microprogram: a load, a landed report or one RK4 step, with the acceleration as a subroutine
  function automatic ctl_t rom_word(input pc_t pc);
    ctl_t w;
    case (pc)
      7'd0:  w = mk(U_BLD,   R_ZERO, R_ZERO, R_ZERO, L_LOAD);
      7'd1:  w = mk(U_BLAND, R_ZERO, R_ZERO, R_ZERO, L_LAND);
      7'd2:  w = mk(U_ADD,   R_VX,   R_ZERO, R_UX,   7'd0);
      7'd3:  w = mk(U_ADD,   R_VY,   R_ZERO, R_UY,   7'd0);
      7'd4:  w = mk(U_CALL,  R_ZERO, R_ZERO, R_ZERO, L_ACC);
      7'd5:  w = mk(U_ADD,   R_KX,   R_ZERO, R_SKX,  7'd0);
      7'd6:  w = mk(U_ADD,   R_KY,   R_ZERO, R_SKY,  7'd0);
      7'd7:  w = mk(U_ADD,   R_VX,   R_ZERO, R_SPX,  7'd0);
      7'd8:  w = mk(U_ADD,   R_VY,   R_ZERO, R_SPY,  7'd0);
      7'd9:  w = mk(U_MULH,  R_H,    R_KX,   R_A,    7'd0);
      7'd10: w = mk(U_ADD,   R_VX,   R_A,    R_UX,   7'd0);
      7'd11: w = mk(U_MULH,  R_H,    R_KY,   R_A,    7'd0);
      7'd12: w = mk(U_ADD,   R_VY,   R_A,    R_UY,   7'd0);
      7'd13: w = mk(U_CALL,  R_ZERO, R_ZERO, R_ZERO, L_ACC);
      7'd14: w = mk(U_ADD,   R_KX,   R_KX,   R_A,    7'd0);
      7'd15: w = mk(U_ADD,   R_SKX,  R_A,    R_SKX,  7'd0);
      7'd16: w = mk(U_ADD,   R_KY,   R_KY,   R_A,    7'd0);
      7'd17: w = mk(U_ADD,   R_SKY,  R_A,    R_SKY,  7'd0);
      7'd18: w = mk(U_ADD,   R_UX,   R_UX,   R_A,    7'd0);
      7'd19: w = mk(U_ADD,   R_SPX,  R_A,    R_SPX,  7'd0);
      7'd20: w = mk(U_ADD,   R_UY,   R_UY,   R_A,    7'd0);
      7'd21: w = mk(U_ADD,   R_SPY,  R_A,    R_SPY,  7'd0);
      7'd22: w = mk(U_MULH,  R_H,    R_KX,   R_A,    7'd0);
      7'd23: w = mk(U_ADD,   R_VX,   R_A,    R_UX,   7'd0);
      7'd24: w = mk(U_MULH,  R_H,    R_KY,   R_A,    7'd0);
      7'd25: w = mk(U_ADD,   R_VY,   R_A,    R_UY,   7'd0);
      7'd26: w = mk(U_CALL,  R_ZERO, R_ZERO, R_ZERO, L_ACC);
      7'd27: w = mk(U_ADD,   R_KX,   R_KX,   R_A,    7'd0);
      7'd28: w = mk(U_ADD,   R_SKX,  R_A,    R_SKX,  7'd0);
      7'd29: w = mk(U_ADD,   R_KY,   R_KY,   R_A,    7'd0);
      7'd30: w = mk(U_ADD,   R_SKY,  R_A,    R_SKY,  7'd0);
      7'd31: w = mk(U_ADD,   R_UX,   R_UX,   R_A,    7'd0);
      7'd32: w = mk(U_ADD,   R_SPX,  R_A,    R_SPX,  7'd0);
      7'd33: w = mk(U_ADD,   R_UY,   R_UY,   R_A,    7'd0);
      7'd34: w = mk(U_ADD,   R_SPY,  R_A,    R_SPY,  7'd0);
      7'd35: w = mk(U_MUL,   R_H,    R_KX,   R_A,    7'd0);
      7'd36: w = mk(U_ADD,   R_VX,   R_A,    R_UX,   7'd0);
      7'd37: w = mk(U_MUL,   R_H,    R_KY,   R_A,    7'd0);
      7'd38: w = mk(U_ADD,   R_VY,   R_A,    R_UY,   7'd0);
      7'd39: w = mk(U_CALL,  R_ZERO, R_ZERO, R_ZERO, L_ACC);
      7'd40: w = mk(U_ADD,   R_SKX,  R_KX,   R_SKX,  7'd0);
      7'd41: w = mk(U_ADD,   R_SKY,  R_KY,   R_SKY,  7'd0);
      7'd42: w = mk(U_ADD,   R_SPX,  R_UX,   R_SPX,  7'd0);
      7'd43: w = mk(U_ADD,   R_SPY,  R_UY,   R_SPY,  7'd0);
      7'd44: w = mk(U_MUL,   R_H,    R_SKX,  R_A,    7'd0);
      7'd45: w = mk(U_R6,    R_A,    R_ZERO, R_A,    7'd0);
      7'd46: w = mk(U_ADD,   R_VX,   R_A,    R_VX,   7'd0);
      7'd47: w = mk(U_MUL,   R_H,    R_SKY,  R_A,    7'd0);
      7'd48: w = mk(U_R6,    R_A,    R_ZERO, R_A,    7'd0);
      7'd49: w = mk(U_ADD,   R_VY,   R_A,    R_VY,   7'd0);
      7'd50: w = mk(U_MUL,   R_H,    R_SPX,  R_A,    7'd0);
      7'd51: w = mk(U_R6,    R_A,    R_ZERO, R_A,    7'd0);
      7'd52: w = mk(U_ADD,   R_X,    R_A,    R_X,    7'd0);
      7'd53: w = mk(U_MUL,   R_H,    R_SPY,  R_A,    7'd0);
      7'd54: w = mk(U_R6,    R_A,    R_ZERO, R_A,    7'd0);
      7'd55: w = mk(U_ADD,   R_Y,    R_A,    R_Y,    7'd0);
      7'd56: w = mk(U_DONE,  R_ZERO, R_ZERO, R_ZERO, 7'd0);
      7'd57: w = mk(U_LOAD,  R_ZERO, R_ZERO, R_ZERO, 7'd0);
      7'd58: w = mk(U_DONE,  R_ZERO, R_ZERO, R_ZERO, 7'd0);
      7'd59: w = mk(U_DONEL, R_ZERO, R_ZERO, R_ZERO, 7'd0);
      // acceleration of (UX, UY) into (KX, KY)
      7'd60: w = mk(U_SQ,    R_UX,   R_UX,   R_ZERO, 7'd0);
      7'd61: w = mk(U_SQA,   R_UY,   R_UY,   R_ZERO, 7'd0);
      7'd62: w = mk(U_SQRT,  R_ZERO, R_ZERO, R_S,    7'd0);
      7'd63: w = mk(U_MUL,   R_S,    R_UX,   R_T,    7'd0);
      7'd64: w = mk(U_MUL,   R_D,    R_T,    R_T,    7'd0);
      7'd65: w = mk(U_SUB,   R_ZERO, R_T,    R_T,    7'd0);
      7'd66: w = mk(U_MUL,   R_MU,   R_UX,   R_A,    7'd0);
      7'd67: w = mk(U_SUB,   R_T,    R_A,    R_KX,   7'd0);
      7'd68: w = mk(U_MUL,   R_S,    R_UY,   R_T,    7'd0);
      7'd69: w = mk(U_MUL,   R_D,    R_T,    R_T,    7'd0);
      7'd70: w = mk(U_SUB,   R_ZERO, R_G,    R_A,    7'd0);
      7'd71: w = mk(U_SUB,   R_A,    R_T,    R_T,    7'd0);
      7'd72: w = mk(U_MUL,   R_MU,   R_UY,   R_A,    7'd0);
      7'd73: w = mk(U_SUB,   R_T,    R_A,    R_KY,   7'd0);
      7'd74: w = mk(U_RET,   R_ZERO, R_ZERO, R_ZERO, 7'd0);
      default: w = mk(U_DONE, R_ZERO, R_ZERO, R_ZERO, 7'd0);
    endcase
    rom_word = w;
  endfunction

endpackage

// ===== rtl/rkp_ifs.sv =====
interface rkp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] load_x;
  logic [63:0] load_y;
  logic [63:0] load_vx;
  logic [63:0] load_vy;
  modport source(output valid, op, load_x, load_y, load_vx, load_vy, input ready);
  modport sink(input valid, op, load_x, load_y, load_vx, load_vy, output ready);
endinterface

interface rkp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] pos_x;
  logic [63:0] pos_y;
  logic [63:0] vel_x;
  logic [63:0] vel_y;
  logic        landed;
  modport source(output valid, pos_x, pos_y, vel_x, vel_y, landed, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, landed, output ready);
endinterface

// ===== rtl/rk4_projectile_drag_step_unit.sv =====
// Channel  Direction  Handshake      Payload
// in_ch    sink       valid / ready  op, load_x, load_y, load_vx, load_vy
// out_ch   source     valid / ready  pos_x, pos_y, vel_x, vel_y, landed
// cfg      APB slave  psel / penable drag_per_mass, friction, gravity, step_size
//
// A step item runs 117 microwords, each with a fetch and an execute state, plus
// the unit waits: 42 multiplies on the shared 32x32 multiplier, four square roots
// and four divides by six. A load or a landed item branches past the step to its
// own done word.
// Reset clears the state and restores the register defaults, with no sweep.
// A finished item waits in the output register; the next item is taken meanwhile.
module rk4_projectile_drag_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  rkp_in_if.sink      in_ch,
  rkp_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_DRAG     = 2'd0;
  localparam logic [1:0] REG_FRICTION = 2'd1;
  localparam logic [1:0] REG_GRAVITY  = 2'd2;
  localparam logic [1:0] REG_STEP     = 2'd3;

  logic [62:0]  drag_r, fric_r, grav_r, step_r;
  logic [63:0]  x_r, y_r, vx_r, vy_r;
  logic [63:0]  ld_x_r, ld_y_r, ld_vx_r, ld_vy_r;
  logic         op_r;
  logic [63:0]  mem [16];
  logic [63:0]  rd_a_r, rd_b_r;
  logic [127:0] sq_r;
  logic [63:0]  opa, opb, wres;
  logic [63:0]  o_x_r, o_y_r, o_vx_r, o_vy_r;
  logic         o_land_r, out_valid_r;
  logic         in_acc;
  logic         mul_start, mul_done, sqrt_done, div_done, unit_done;
  logic [63:0]  mul_res, sqrt_res, div_res;
  logic [127:0] mul_prod;
  rkp_pkg::seq_in_t  si;
  rkp_pkg::seq_out_t so;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    sat_add = (s[64] != s[63]) ? (s[64] ? rkp_pkg::SMIN : rkp_pkg::SMAX) : s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    sat_sub = (s[64] != s[63]) ? (s[64] ? rkp_pkg::SMIN : rkp_pkg::SMAX) : s[63:0];
  endfunction

  function automatic logic [63:0] pick(input rkp_pkg::rsel_t s, input logic [63:0] rd,
                                       input logic [63:0] x, input logic [63:0] y,
                                       input logic [63:0] vx, input logic [63:0] vy,
                                       input logic [62:0] d, input logic [62:0] mu,
                                       input logic [62:0] g, input logic [62:0] h);
    logic [63:0] v;
    if (!s[4]) begin
      v = rd;
    end else begin
      case (s)
        rkp_pkg::R_X:  v = x;
        rkp_pkg::R_Y:  v = y;
        rkp_pkg::R_VX: v = vx;
        rkp_pkg::R_VY: v = vy;
        rkp_pkg::R_D:  v = {1'b0, d};
        rkp_pkg::R_MU: v = {1'b0, mu};
        rkp_pkg::R_G:  v = {1'b0, g};
        rkp_pkg::R_H:  v = {1'b0, h};
        default:       v = '0;
      endcase
    end
    pick = v;
  endfunction

  // Sequencer
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = so.idle;

  always_comb begin
    si.start = in_acc;
    si.is_load = !op_r;
    si.at_ground = $signed(y_r) <= $signed(rkp_pkg::THRESH);
    si.unit_done = unit_done;
    si.out_free = !out_valid_r;
  end

  rkp_seq u_seq (.clk(clk), .rst_n(rst_n), .si(si), .so(so));

  // Scratch file: registered reads on two ports, one write
  always_ff @(posedge clk) begin
    rd_a_r <= mem[so.ctl.src_a[3:0]];
    rd_b_r <= mem[so.ctl.src_b[3:0]];
    if (so.wr_en && !so.ctl.dst[4]) begin
      mem[so.ctl.dst[3:0]] <= wres;
    end
  end

  always_comb begin
    opa = pick(so.ctl.src_a, rd_a_r, x_r, y_r, vx_r, vy_r, drag_r, fric_r, grav_r, step_r);
    opb = pick(so.ctl.src_b, rd_b_r, x_r, y_r, vx_r, vy_r, drag_r, fric_r, grav_r, step_r);
  end

  // Shared units
  assign mul_start = so.issue && (so.ctl.op inside {rkp_pkg::U_MUL, rkp_pkg::U_MULH,
                                                   rkp_pkg::U_SQ, rkp_pkg::U_SQA});

  rkp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(opa), .b(opb),
    .half(so.ctl.op == rkp_pkg::U_MULH), .res(mul_res), .prod(mul_prod), .done(mul_done)
  );

  rkp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(so.issue && (so.ctl.op == rkp_pkg::U_SQRT)),
    .rad(sq_r), .res(sqrt_res), .done(sqrt_done)
  );

  rkp_div6 u_div6 (
    .clk(clk), .rst_n(rst_n), .start(so.issue && (so.ctl.op == rkp_pkg::U_R6)),
    .a(opa), .res(div_res), .done(div_done)
  );

  // Select the finishing unit and the write-back value
  always_comb begin
    case (so.ctl.op)
      rkp_pkg::U_MUL, rkp_pkg::U_MULH, rkp_pkg::U_SQ, rkp_pkg::U_SQA: unit_done = mul_done;
      rkp_pkg::U_SQRT: unit_done = sqrt_done;
      rkp_pkg::U_R6:   unit_done = div_done;
      default:         unit_done = 1'b0;
    endcase
    case (so.ctl.op)
      rkp_pkg::U_ADD:  wres = sat_add(opa, opb);
      rkp_pkg::U_SUB:  wres = sat_sub(opa, opb);
      rkp_pkg::U_SQRT: wres = sqrt_res;
      rkp_pkg::U_R6:   wres = div_res;
      default:         wres = mul_res;
    endcase
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_ch.op;
      ld_x_r <= in_ch.load_x;
      ld_y_r <= in_ch.load_y;
      ld_vx_r <= in_ch.load_vx;
      ld_vy_r <= in_ch.load_vy;
    end
  end

  // Speed-squared accumulator
  always_ff @(posedge clk) begin
    if (so.wr_en && (so.ctl.op == rkp_pkg::U_SQ)) begin
      sq_r <= mul_prod;
    end else if (so.wr_en && (so.ctl.op == rkp_pkg::U_SQA)) begin
      sq_r <= sq_r + mul_prod;
    end
  end

  // Projectile state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
    end else if (so.wr_en && (so.ctl.op == rkp_pkg::U_LOAD)) begin
      x_r <= ld_x_r;
      y_r <= ld_y_r;
      vx_r <= ld_vx_r;
      vy_r <= ld_vy_r;
    end else if (so.wr_en && so.ctl.dst[4]) begin
      case (so.ctl.dst)
        rkp_pkg::R_X:  x_r <= wres;
        rkp_pkg::R_Y:  y_r <= wres;
        rkp_pkg::R_VX: vx_r <= wres;
        rkp_pkg::R_VY: vy_r <= wres;
        default: ;
      endcase
    end
  end

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r <= rkp_pkg::DRAG_RST;
      fric_r <= rkp_pkg::FRICTION_RST;
      grav_r <= rkp_pkg::GRAVITY_RST;
      step_r <= rkp_pkg::STEP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_DRAG:     drag_r <= pwdata[62:0];
        REG_FRICTION: fric_r <= pwdata[62:0];
        REG_GRAVITY:  grav_r <= pwdata[62:0];
        REG_STEP:     step_r <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_DRAG:     prdata = {1'b0, drag_r};
      REG_FRICTION: prdata = {1'b0, fric_r};
      REG_GRAVITY:  prdata = {1'b0, grav_r};
      REG_STEP:     prdata = {1'b0, step_r};
      default:      prdata = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (so.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (so.done) begin
      o_x_r <= x_r;
      o_y_r <= y_r;
      o_vx_r <= vx_r;
      o_vy_r <= vy_r;
      o_land_r <= (so.ctl.op == rkp_pkg::U_DONEL);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = o_x_r;
  assign out_ch.pos_y = o_y_r;
  assign out_ch.vel_x = o_vx_r;
  assign out_ch.vel_y = o_vy_r;
  assign out_ch.landed = o_land_r;

  // Checks
  a_one_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_done, sqrt_done, div_done}))
    else $error("two units finished together");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    so.done |-> !out_valid_r)
    else $error("result written over a waiting item");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    so.wr_en |-> !in_ch.ready)
    else $error("datapath write while idle");

  a_landed_low: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && o_land_r) |-> ($signed(o_y_r) <= $signed(rkp_pkg::THRESH)))
    else $error("landed item above threshold");

endmodule

// ===== rtl/rkp_mul.sv =====
module rkp_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        half,
  output logic [63:0] res,
  output logic [127:0] prod,
  output logic        done
);

  localparam logic [128:0] RND0 = 129'd1 << (rkp_pkg::FRAC_BITS - 1);
  localparam logic [128:0] RND1 = 129'd1 << rkp_pkg::FRAC_BITS;

  logic [63:0]  am_r, bm_r, res_r;
  logic [127:0] acc_r;
  logic         neg_r, half_r, busy_r, done_r;
  logic [2:0]   cnt_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   hs;
  logic [127:0] term;
  logic [128:0] total, qf;
  logic [63:0]  lim, q, rnd_res;

  // One 32x32 partial product per cycle
  always_comb begin
    pa = cnt_r[0] ? am_r[63:32] : am_r[31:0];
    pb = cnt_r[1] ? bm_r[63:32] : bm_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    hs = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
    term = {64'd0, pp} << {hs, 5'd0};
  end

  // Round half away from zero, saturate, restore sign
  always_comb begin
    total = {1'b0, acc_r} + (half_r ? RND1 : RND0);
    qf = half_r ? (total >> (rkp_pkg::FRAC_BITS + 1)) : (total >> rkp_pkg::FRAC_BITS);
    lim = neg_r ? rkp_pkg::SMIN : rkp_pkg::SMAX;
    q = ((|qf[128:64]) || (qf[63:0] > lim)) ? lim : qf[63:0];
    rnd_res = neg_r ? 64'(64'd0 - q) : q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 3'd0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  // Operand and accumulator payload
  always_ff @(posedge clk) begin
    if (start) begin
      am_r <= rkp_pkg::mag(a);
      bm_r <= rkp_pkg::mag(b);
      neg_r <= a[63] ^ b[63];
      half_r <= half;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) begin
        res_r <= rnd_res;
      end else begin
        acc_r <= acc_r + term;
      end
    end
  end

  assign res = res_r;
  assign prod = acc_r;
  assign done = done_r;

endmodule

// ===== rtl/rkp_sqrt.sv =====
module rkp_sqrt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] rad,
  output logic [63:0]  res,
  output logic         done
);

  logic [127:0] rad_r;
  logic [65:0]  rem_r;
  logic [63:0]  root_r;
  logic [5:0]   cnt_r;
  logic         busy_r, done_r;
  logic [67:0]  rem_t, trial;
  logic         ge;

  // One restoring step: two radicand bits in, one root bit out
  always_comb begin
    rem_t = {rem_r, rad_r[127:126]};
    trial = {2'b00, root_r, 2'b01};
    ge = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      rem_r <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[125:0], 2'b00};
      rem_r <= ge ? 66'(rem_t - trial) : rem_t[65:0];
      root_r <= {root_r[62:0], ge};
    end
  end

  assign res = root_r[63] ? rkp_pkg::SMAX : root_r;
  assign done = done_r;

endmodule

// ===== rtl/rkp_div6.sv =====
module rkp_div6 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  output logic [63:0] res,
  output logic        done
);

  // ceil(2^66 / 6): floor(m / 6) is the product shifted down by 66
  localparam logic [63:0] RECIP6 = 64'haaaa_aaaa_aaaa_aaab;

  logic [63:0]  m_r, q_r, res_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         neg_r, busy_r, done_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   hs;
  logic [127:0] term;
  logic [63:0]  rem, qq;

  // One 32x32 partial product of the magnitude and the reciprocal per cycle
  always_comb begin
    pa = cnt_r[0] ? m_r[63:32] : m_r[31:0];
    pb = cnt_r[1] ? RECIP6[63:32] : RECIP6[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    hs = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
    term = {64'd0, pp} << {hs, 5'd0};
  end

  // Remainder from the quotient, round half away from zero
  always_comb begin
    rem = m_r - ((q_r << 2) + (q_r << 1));
    qq = q_r + {63'd0, rem >= 64'd3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 3'd0;
      end else if (busy_r) begin
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  // Accumulate, take the quotient, then round and restore the sign
  always_ff @(posedge clk) begin
    if (start) begin
      m_r <= rkp_pkg::mag(a);
      neg_r <= a[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd5) begin
        res_r <= neg_r ? 64'(64'd0 - qq) : qq;
      end else if (cnt_r == 3'd4) begin
        q_r <= {2'b00, acc_r[127:66]};
      end else begin
        acc_r <= acc_r + term;
      end
    end
  end

  assign res = res_r;
  assign done = done_r;

endmodule

// ===== rtl/rkp_seq.sv =====
module rkp_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  rkp_pkg::seq_in_t si,
  output rkp_pkg::seq_out_t so
);

  rkp_pkg::seq_state_t state_r, state_nxt;
  rkp_pkg::pc_t        pc_r, pc_nxt, link_r, link_nxt;
  rkp_pkg::ctl_t       ctl;
  logic                is_unit, is_alu, is_done;

  assign ctl = rkp_pkg::rom_word(pc_r);

  always_comb begin
    is_unit = ctl.op inside {rkp_pkg::U_MUL, rkp_pkg::U_MULH, rkp_pkg::U_SQ,
                             rkp_pkg::U_SQA, rkp_pkg::U_SQRT, rkp_pkg::U_R6};
    is_alu = ctl.op inside {rkp_pkg::U_ADD, rkp_pkg::U_SUB, rkp_pkg::U_LOAD};
    is_done = ctl.op inside {rkp_pkg::U_DONE, rkp_pkg::U_DONEL};
  end

  // Next state, program counter and return link
  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    link_nxt = link_r;
    case (state_r)
      rkp_pkg::S_IDLE: begin
        if (si.start) begin
          state_nxt = rkp_pkg::S_FETCH;
          pc_nxt = '0;
        end
      end
      rkp_pkg::S_FETCH: state_nxt = rkp_pkg::S_EXEC;
      rkp_pkg::S_EXEC: begin
        state_nxt = rkp_pkg::S_FETCH;
        case (ctl.op)
          rkp_pkg::U_BLD: pc_nxt = si.is_load ? ctl.tgt : 7'(pc_r + 7'd1);
          rkp_pkg::U_BLAND: pc_nxt = si.at_ground ? ctl.tgt : 7'(pc_r + 7'd1);
          rkp_pkg::U_CALL: begin
            link_nxt = 7'(pc_r + 7'd1);
            pc_nxt = ctl.tgt;
          end
          rkp_pkg::U_RET: pc_nxt = link_r;
          default: begin
            if (is_unit) begin
              state_nxt = rkp_pkg::S_WAIT;
            end else if (is_done) begin
              state_nxt = si.out_free ? rkp_pkg::S_IDLE : rkp_pkg::S_EXEC;
            end else begin
              pc_nxt = 7'(pc_r + 7'd1);
            end
          end
        endcase
      end
      rkp_pkg::S_WAIT: begin
        if (si.unit_done) begin
          state_nxt = rkp_pkg::S_FETCH;
          pc_nxt = 7'(pc_r + 7'd1);
        end
      end
      default: state_nxt = rkp_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    so.ctl = ctl;
    so.idle = (state_r == rkp_pkg::S_IDLE);
    so.issue = (state_r == rkp_pkg::S_EXEC) && is_unit;
    so.wr_en = ((state_r == rkp_pkg::S_EXEC) && is_alu) ||
               ((state_r == rkp_pkg::S_WAIT) && si.unit_done);
    so.done = (state_r == rkp_pkg::S_EXEC) && is_done && si.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rkp_pkg::S_IDLE;
      pc_r <= '0;
      link_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      link_r <= link_nxt;
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;

  typedef logic signed [63:0] fx_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam int REG_DRAG     = 0;
  localparam int REG_FRICTION = 1;
  localparam int REG_GRAVITY  = 2;
  localparam int REG_STEP     = 3;

  localparam logic [62:0] REG_MAX = 63'h7fff_ffff_ffff_ffff;
  localparam fx_t FX_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    fx_t  pos_x;
    fx_t  pos_y;
    fx_t  vel_x;
    fx_t  vel_y;
    logic landed;
  } state_item_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  rkp_in_if in_if ();
  rkp_out_if out_if ();

  rk4_projectile_drag_step_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state and register mirror
  fx_t pr_x, pr_y, pr_vx, pr_vy;
  logic [62:0] cfg_mirror [4];

  state_item_t state_q [$];
  int err_count;
  int items_sent;
  int hold_len;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // ---------------- fixed-point predictor ----------------

  function automatic logic [63:0] abs_fx(input fx_t a);
    abs_fx = a[63] ? 64'(64'd0 - a) : a;
  endfunction

  function automatic fx_t clamp66(input logic signed [65:0] w);
    if (w > 66'sh0_7fff_ffff_ffff_ffff) clamp66 = FX_MAX;
    else if (w < -66'sh0_8000_0000_0000_0000) clamp66 = FX_MIN;
    else clamp66 = w[63:0];
  endfunction

  function automatic fx_t add_sat(input fx_t a, input fx_t b);
    logic signed [65:0] w;
    w = a;
    w = w + b;
    add_sat = clamp66(w);
  endfunction

  function automatic fx_t sub_sat(input fx_t a, input fx_t b);
    logic signed [65:0] w;
    w = a;
    w = w - b;
    sub_sat = clamp66(w);
  endfunction

  // round(a*b / 2^sh), ties away from zero, saturated
  function automatic fx_t mul_shift(input fx_t a, input fx_t b, input int sh);
    logic neg;
    logic [127:0] p;
    logic [127:0] q;
    logic [127:0] lim;
    neg = a[63] ^ b[63];
    p = 128'(abs_fx(a)) * 128'(abs_fx(b));
    p = p + (128'd1 << (sh - 1));
    q = p >> sh;
    lim = neg ? (128'd1 << 63) : 128'(FX_MAX);
    if (q > lim) q = lim;
    mul_shift = neg ? 64'(64'd0 - q[63:0]) : q[63:0];
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    fx_mul = mul_shift(a, b, rkp_pkg::FRAC_BITS);
  endfunction

  function automatic fx_t div6_round(input fx_t a);
    logic [63:0] m;
    logic [63:0] q;
    m = abs_fx(a);
    q = m / 6 + (((m % 6) >= 3) ? 64'd1 : 64'd0);
    div6_round = a[63] ? 64'(64'd0 - q) : q;
  endfunction

  function automatic fx_t speed_of(input fx_t vx, input fx_t vy);
    logic [127:0] sum;
    logic [63:0] r;
    logic [63:0] c;
    sum = 128'(abs_fx(vx)) * 128'(abs_fx(vx)) + 128'(abs_fx(vy)) * 128'(abs_fx(vy));
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= sum) r = c;
    end
    speed_of = (r > 64'(FX_MAX)) ? FX_MAX : r;
  endfunction

  task automatic drag_accel(input fx_t vx, input fx_t vy, output fx_t ax, output fx_t ay);
    fx_t s, d, mu, g;
    s = speed_of(vx, vy);
    d = {1'b0, cfg_mirror[REG_DRAG]};
    mu = {1'b0, cfg_mirror[REG_FRICTION]};
    g = {1'b0, cfg_mirror[REG_GRAVITY]};
    ax = sub_sat(sub_sat(0, fx_mul(d, fx_mul(s, vx))), fx_mul(mu, vx));
    ay = sub_sat(sub_sat(-g, fx_mul(d, fx_mul(s, vy))), fx_mul(mu, vy));
  endtask

  function automatic fx_t weighted_sum(input fx_t k1, input fx_t k2, input fx_t k3,
                                       input fx_t k4);
    fx_t s;
    s = add_sat(k1, add_sat(k2, k2));
    s = add_sat(s, add_sat(k3, k3));
    weighted_sum = add_sat(s, k4);
  endfunction

  // Advance the predicted trajectory by one item
  task automatic predict_item(input logic op, input fx_t lx, input fx_t ly,
                              input fx_t lvx, input fx_t lvy, output state_item_t res);
    fx_t h, vx, vy;
    fx_t k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y;
    fx_t u2x, u2y, u3x, u3y, u4x, u4y;
    res.landed = 1'b0;
    if (op == OP_LOAD) begin
      pr_x = lx;
      pr_y = ly;
      pr_vx = lvx;
      pr_vy = lvy;
    end else if (pr_y > fx_t'(rkp_pkg::THRESH)) begin
      h = {1'b0, cfg_mirror[REG_STEP]};
      vx = pr_vx;
      vy = pr_vy;
      drag_accel(vx, vy, k1x, k1y);
      u2x = add_sat(vx, mul_shift(h, k1x, rkp_pkg::FRAC_BITS + 1));
      u2y = add_sat(vy, mul_shift(h, k1y, rkp_pkg::FRAC_BITS + 1));
      drag_accel(u2x, u2y, k2x, k2y);
      u3x = add_sat(vx, mul_shift(h, k2x, rkp_pkg::FRAC_BITS + 1));
      u3y = add_sat(vy, mul_shift(h, k2y, rkp_pkg::FRAC_BITS + 1));
      drag_accel(u3x, u3y, k3x, k3y);
      u4x = add_sat(vx, fx_mul(h, k3x));
      u4y = add_sat(vy, fx_mul(h, k3y));
      drag_accel(u4x, u4y, k4x, k4y);
      pr_vx = add_sat(vx, div6_round(fx_mul(h, weighted_sum(k1x, k2x, k3x, k4x))));
      pr_vy = add_sat(vy, div6_round(fx_mul(h, weighted_sum(k1y, k2y, k3y, k4y))));
      pr_x = add_sat(pr_x, div6_round(fx_mul(h, weighted_sum(vx, u2x, u3x, u4x))));
      pr_y = add_sat(pr_y, div6_round(fx_mul(h, weighted_sum(vy, u2y, u3y, u4y))));
    end else begin
      res.landed = 1'b1;
    end
    res.pos_x = pr_x;
    res.pos_y = pr_y;
    res.vel_x = pr_vx;
    res.vel_y = pr_vy;
  endtask

  // ---------------- channel drivers ----------------

  // Offer one item after a random gap; valid stays high when the gap is zero
  task automatic send_item(input logic op, input fx_t lx, input fx_t ly,
                           input fx_t lvx, input fx_t lvy);
    int gap;
    state_item_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.load_x <= lx;
    in_if.load_y <= ly;
    in_if.load_vx <= lvx;
    in_if.load_vy <= lvy;
    @(posedge clk iff in_if.ready);
    predict_item(op, lx, ly, lvx, lvy, res);
    state_q.push_back(res);
    items_sent++;
  endtask

  // Drop valid and drain every outstanding result
  task automatic drain;
    in_if.valid <= 1'b0;
    while (state_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Result checker with random stalls and an optional long hold
  initial begin
    int stall;
    state_item_t want;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = (hold_len > 0) ? hold_len : $urandom_range(0, 19);
      hold_len = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk iff out_if.valid);
      if (state_q.size() == 0) begin
        report("unexpected item", out_if.pos_x, 64'd0);
      end else begin
        want = state_q.pop_front();
        if (out_if.pos_x !== want.pos_x) report("pos_x", out_if.pos_x, want.pos_x);
        if (out_if.pos_y !== want.pos_y) report("pos_y", out_if.pos_y, want.pos_y);
        if (out_if.vel_x !== want.vel_x) report("vel_x", out_if.vel_x, want.vel_x);
        if (out_if.vel_y !== want.vel_y) report("vel_y", out_if.vel_y, want.vel_y);
        if (out_if.landed !== want.landed) report("landed", out_if.landed, want.landed);
      end
    end
  end

  // ---------------- register port ----------------

  task automatic reg_write(input int idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_mirror[idx] = val[62:0];
    @(posedge clk);
  endtask

  task automatic reg_check(input int idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 5'(idx * 8);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    if (prdata !== {1'b0, cfg_mirror[idx]}) report("register read", prdata,
                                                   {1'b0, cfg_mirror[idx]});
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fx_t rand_word();
    rand_word = {$urandom, $urandom};
  endfunction

  // Random value up to limit in whole units, random fraction and sign
  function automatic fx_t rand_fx(input int unsigned limit);
    fx_t v;
    v = (fx_t'($urandom_range(0, limit)) <<< rkp_pkg::FRAC_BITS) | fx_t'($urandom);
    rand_fx = $urandom_range(0, 1) ? -v : v;
  endfunction

  // ---------------- tests ----------------

  task automatic test_reset_defaults;
    for (int i = 0; i < 4; i++) reg_check(i);
    // height zero after reset: holds and reports landed
    send_item(OP_STEP, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_extremes;
    send_item(OP_LOAD, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_LOAD, FX_MIN, FX_MAX, FX_MIN, FX_MIN);
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_LOAD, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_item(OP_STEP, 0, 0, 0, 0);
    // threshold edge: at threshold lands, one above steps
    send_item(OP_LOAD, 0, fx_t'(rkp_pkg::THRESH), 64'sd1 <<< 40, 64'sd3 <<< 40);
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_LOAD, -1, fx_t'(rkp_pkg::THRESH) + 1, -1, -1);
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_LOAD, 64'sd5 <<< 40, 64'sd100 <<< 40, 64'sd20 <<< 40, 64'sd30 <<< 40);
    repeat (4) send_item(OP_STEP, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_register_extremes;
    // zero step leaves the state unchanged
    reg_write(REG_STEP, 64'd0);
    send_item(OP_LOAD, 64'sd1 <<< 40, 64'sd10 <<< 40, 64'sd7 <<< 40, -(64'sd2 <<< 40));
    send_item(OP_STEP, 0, 0, 0, 0);
    drain();
    // top bit of the write data is dropped
    for (int i = 0; i < 4; i++) reg_write(i, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 4; i++) reg_check(i);
    send_item(OP_LOAD, 64'sd1 <<< 40, 64'sd10 <<< 40, 64'sd7 <<< 40, -(64'sd2 <<< 40));
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_STEP, 0, 0, 0, 0);
    drain();
    reg_write(REG_DRAG, 64'd0);
    reg_write(REG_FRICTION, 64'd0);
    reg_write(REG_GRAVITY, 64'd0);
    reg_write(REG_STEP, 64'd1);
    send_item(OP_LOAD, rand_word(), 64'sd50 <<< 40, rand_word(), rand_word());
    send_item(OP_STEP, 0, 0, 0, 0);
    drain();
    for (int i = 0; i < 4; i++) reg_write(i, {1'b0, REG_MAX});
    send_item(OP_LOAD, 0, 64'sd1 <<< 40, 64'sd1 <<< 30, 64'sd1 <<< 30);
    send_item(OP_STEP, 0, 0, 0, 0);
    drain();
  endtask

  task automatic random_config;
    case ($urandom_range(0, 5))
      0: reg_write(REG_DRAG, rand_word());
      1: reg_write(REG_DRAG, 64'd0);
      default: reg_write(REG_DRAG, 64'($urandom_range(0, 32'h7fff_ffff)) << 4);
    endcase
    reg_write(REG_FRICTION, ($urandom_range(0, 7) == 0) ? rand_word()
                                                        : 64'($urandom_range(0, 1 << 30)));
    reg_write(REG_GRAVITY, ($urandom_range(0, 7) == 0) ? rand_word()
                                                       : 64'(rand_fx(20)) & 64'h3f_ffff_ffff_ffff);
    case ($urandom_range(0, 4))
      0: reg_write(REG_STEP, rand_word());
      1: reg_write(REG_STEP, 64'($urandom_range(1, 1000)));
      default: reg_write(REG_STEP, 64'($urandom) << $urandom_range(0, 9));
    endcase
  endtask

  task automatic test_random_flights;
    int steps;
    fx_t y;
    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      while (items_sent < 60 * (phase + 1) + 40) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_LOAD, rand_word(), rand_word(), rand_word(), rand_word());
        end else begin
          y = rand_fx(60);
          if ($urandom_range(0, 5) != 0 && y < 0) y = -y;
          send_item(OP_LOAD, rand_fx(1000), y, rand_fx(200), rand_fx(200));
        end
        steps = $urandom_range(2, 20);
        repeat (steps) send_item(OP_STEP, rand_word(), rand_word(), rand_word(), rand_word());
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    reg_write(REG_STEP, 64'd109951163);
    hold_len = 3000;
    no_gaps = 1'b1;
    send_item(OP_LOAD, 0, 64'sd20 <<< 40, 64'sd10 <<< 40, 64'sd15 <<< 40);
    repeat (3) send_item(OP_STEP, 0, 0, 0, 0);
    repeat (3) send_item(OP_LOAD, rand_word(), rand_word(), rand_word(), rand_word());
    repeat (3) send_item(OP_STEP, 0, 0, 0, 0);
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.load_x = '0;
    in_if.load_y = '0;
    in_if.load_vx = '0;
    in_if.load_vy = '0;
    err_count = 0;
    items_sent = 0;
    hold_len = 0;
    no_gaps = 1'b0;
    cfg_mirror[REG_DRAG] = rkp_pkg::DRAG_RST;
    cfg_mirror[REG_FRICTION] = rkp_pkg::FRICTION_RST;
    cfg_mirror[REG_GRAVITY] = rkp_pkg::GRAVITY_RST;
    cfg_mirror[REG_STEP] = rkp_pkg::STEP_RST;
    pr_x = 0;
    pr_y = 0;
    pr_vx = 0;
    pr_vy = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_register_extremes();
    test_backpressure();
    test_random_flights();

    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rkp_pkg.sv
rtl/rkp_ifs.sv
rtl/rkp_mul.sv
rtl/rkp_sqrt.sv
rtl/rkp_div6.sv
rtl/rkp_seq.sv
rtl/rk4_projectile_drag_step_unit.sv
test/tb_top.sv
